// ===== hdl/sfcb_pkg.sv =====
package sfcb_pkg;

  localparam int MAX_ENTITIES_DEF   = 1024;
  localparam int MAX_PLANES_DEF     = 16;
  localparam int WORDS_PER_CELL_DEF = 32;

  localparam int OP_W     = 2;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 32;
  localparam int MASK_W   = 32;
  localparam int OFF_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int ROW_W    = 4 * VALUE_W;
  localparam int OPA_W    = VALUE_W + 1;
  localparam int PROD_W   = OPA_W + VALUE_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int ENT_W    = INDEX_W + OFF_W;

  localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_PLANE = 2'd0,
    OP_LOAD_POSE  = 2'd1,
    OP_CULL       = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_EN     = 1'b1;

  typedef struct packed {
    logic clear;
    logic mul;
    logic acc;
  } mac_ctl_t;

endpackage

// ===== hdl/sfcb_if.sv =====
interface sfcb_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [sfcb_pkg::OP_W-1:0]             op;
  logic [sfcb_pkg::INDEX_W-1:0]          index;
  logic signed [sfcb_pkg::VALUE_W-1:0]   value_a;
  logic signed [sfcb_pkg::VALUE_W-1:0]   value_b;
  logic signed [sfcb_pkg::VALUE_W-1:0]   value_c;
  logic signed [sfcb_pkg::VALUE_W-1:0]   value_d;
  logic [sfcb_pkg::MASK_W-1:0]           candidate_bits;
  logic [sfcb_pkg::MASK_W-1:0]           seen_bits;

  modport source (output valid, op, index, value_a, value_b, value_c, value_d,
                  candidate_bits, seen_bits, input ready);
  modport sink (input valid, op, index, value_a, value_b, value_c, value_d,
                candidate_bits, seen_bits, output ready);
endinterface

interface sfcb_out_if;
  logic                        valid;
  logic                        ready;
  logic [sfcb_pkg::MASK_W-1:0] visible_bits;

  modport source (output valid, visible_bits, input ready);
  modport sink (input valid, visible_bits, output ready);
endinterface

// ===== hdl/sfcb_mac.sv =====
module sfcb_mac (
  input  logic                                clk,
  input  sfcb_pkg::mac_ctl_t                  ctl,
  input  logic signed [sfcb_pkg::OPA_W-1:0]   op_a,
  input  logic signed [sfcb_pkg::VALUE_W-1:0] op_b,
  output logic                                not_pos
);

  logic signed [sfcb_pkg::PROD_W-1:0] prod_r;
  logic signed [sfcb_pkg::ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= op_a * op_b;
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.acc) begin
      acc_r <= acc_r + sfcb_pkg::ACC_W'(prod_r);
    end
  end

  assign not_pos = acc_r[sfcb_pkg::ACC_W-1] || (acc_r == '0);

endmodule

// ===== hdl/sphere_frustum_cull_bitmask.sv =====
// Channel  | Direction | Payload
// in_if    | sink      | op, index, value_a..value_d, candidate_bits, seen_bits
// out_if   | source    | visible_bits
// cfg_*    | write     | cfg_we, cfg_index, cfg_data
//
// Load items and pass-through culls present their result in the cycle after the transfer.
// A cull scans the 32 entities, runs RD, MUL, FIN, CHECK per plane tested, then DONE;
// the shared multiply-accumulate unit forms one product per cycle, four per plane.
// Reset is synchronous and active low; the plane and pose memories are not cleared.
// The input is taken whenever the sequencer is idle and the output register is free
// or being drained, so a new item waits until the previous result has been taken.
module sphere_frustum_cull_bitmask #(
  parameter int MAX_ENTITIES   = sfcb_pkg::MAX_ENTITIES_DEF,
  parameter int MAX_PLANES     = sfcb_pkg::MAX_PLANES_DEF,
  parameter int WORDS_PER_CELL = sfcb_pkg::WORDS_PER_CELL_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sfcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfcb_pkg::CFG_DATA_W-1:0]     cfg_data,
  sfcb_in_if.sink                             in_if,
  sfcb_out_if.source                          out_if
);

  localparam int PlaneAw = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int PoseAw  = $clog2(MAX_ENTITIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_MUL,
    ST_FIN,
    ST_CHECK,
    ST_DONE
  } state_t;

  state_t                               state_r, state_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [sfcb_pkg::MASK_W-1:0]          out_bits_r, out_bits_nxt;
  logic [sfcb_pkg::COUNT_W-1:0]         plane_count_r, plane_count_nxt;
  logic                                 draw_en_r, draw_en_nxt;
  logic [sfcb_pkg::COUNT_W-1:0]         np_r, np_nxt;
  logic [sfcb_pkg::COUNT_W-1:0]         plane_r, plane_nxt;
  logic [sfcb_pkg::INDEX_W-1:0]         idx_r, idx_nxt;
  logic [sfcb_pkg::MASK_W-1:0]          cand_r, cand_nxt;
  logic [sfcb_pkg::MASK_W-1:0]          seen_r, seen_nxt;
  logic [sfcb_pkg::MASK_W-1:0]          vis_r, vis_nxt;
  logic [sfcb_pkg::OFF_W:0]             off_r, off_nxt;
  logic [1:0]                           k_r, k_nxt;

  logic [sfcb_pkg::ROW_W-1:0]           plane_mem [MAX_PLANES];
  logic [sfcb_pkg::ROW_W-1:0]           pose_mem [MAX_ENTITIES];
  logic [sfcb_pkg::ROW_W-1:0]           plane_q_r;
  logic [sfcb_pkg::ROW_W-1:0]           pose_q_r;

  logic                                 in_fire;
  logic                                 out_free;
  logic                                 plane_we;
  logic                                 pose_we;
  logic [sfcb_pkg::ROW_W-1:0]           wr_row;
  logic [sfcb_pkg::OFF_W-1:0]           bit_sel;
  logic [sfcb_pkg::ENT_W-1:0]           ent;
  logic                                 tested;
  logic [sfcb_pkg::COUNT_W-1:0]         np_sat;
  sfcb_pkg::mac_ctl_t                   mac_ctl;
  logic signed [sfcb_pkg::OPA_W-1:0]    op_a;
  logic signed [sfcb_pkg::VALUE_W-1:0]  op_b;
  logic                                 not_pos;

  assign out_free      = !out_valid_r || out_if.ready;
  assign in_if.ready   = (state_r == ST_IDLE) && out_free;
  assign in_fire       = in_if.valid && in_if.ready;
  assign out_if.valid  = out_valid_r;
  assign out_if.visible_bits = out_bits_r;

  assign wr_row  = {in_if.value_d, in_if.value_c, in_if.value_b, in_if.value_a};
  assign plane_we = in_fire && (in_if.op == sfcb_pkg::OP_LOAD_PLANE)
                    && (32'(in_if.index) < MAX_PLANES);
  assign pose_we  = in_fire && (in_if.op == sfcb_pkg::OP_LOAD_POSE)
                    && (32'(in_if.index) < MAX_ENTITIES);

  assign bit_sel = 5'd31 - off_r[sfcb_pkg::OFF_W-1:0];
  assign ent     = {idx_r, off_r[sfcb_pkg::OFF_W-1:0]};
  assign tested  = cand_r[bit_sel] && !seen_r[bit_sel] && (32'(ent) < MAX_ENTITIES);
  assign np_sat  = (32'(plane_count_r) > MAX_PLANES) ? sfcb_pkg::COUNT_W'(MAX_PLANES)
                                                      : plane_count_r;

  always_ff @(posedge clk) begin
    if (plane_we) begin
      plane_mem[PlaneAw'(in_if.index)] <= wr_row;
    end
    plane_q_r <= plane_mem[PlaneAw'(plane_r)];
  end

  always_ff @(posedge clk) begin
    if (pose_we) begin
      pose_mem[PoseAw'(in_if.index)] <= wr_row;
    end
    pose_q_r <= pose_mem[PoseAw'(ent)];
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (k_r)
      2'd0: begin
        op_a = sfcb_pkg::OPA_W'($signed(plane_q_r[31:0]));
        op_b = $signed(pose_q_r[31:0]);
      end
      2'd1: begin
        op_a = sfcb_pkg::OPA_W'($signed(plane_q_r[63:32]));
        op_b = $signed(pose_q_r[63:32]);
      end
      2'd2: begin
        op_a = sfcb_pkg::OPA_W'($signed(plane_q_r[95:64]));
        op_b = $signed(pose_q_r[95:64]);
      end
      2'd3: begin
        op_a = sfcb_pkg::OPA_W'($signed(plane_q_r[127:96]))
             + sfcb_pkg::OPA_W'($signed(pose_q_r[127:96]));
        op_b = sfcb_pkg::Q_ONE;
      end
    endcase
  end

  sfcb_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .op_a    (op_a),
    .op_b    (op_b),
    .not_pos (not_pos)
  );

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_bits_nxt    = out_bits_r;
    plane_count_nxt = plane_count_r;
    draw_en_nxt     = draw_en_r;
    np_nxt          = np_r;
    plane_nxt       = plane_r;
    idx_nxt         = idx_r;
    cand_nxt        = cand_r;
    seen_nxt        = seen_r;
    vis_nxt         = vis_r;
    off_nxt         = off_r;
    k_nxt           = k_r;
    mac_ctl         = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        sfcb_pkg::CFG_PLANE_COUNT: plane_count_nxt = cfg_data;
        sfcb_pkg::CFG_DRAW_EN:     draw_en_nxt     = cfg_data[0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_bits_nxt  = '0;
          if (in_if.op == sfcb_pkg::OP_CULL) begin
            out_bits_nxt = in_if.seen_bits;
            if (draw_en_r && (32'(in_if.index) < WORDS_PER_CELL)) begin
              out_valid_nxt = 1'b0;
              idx_nxt       = in_if.index;
              cand_nxt      = in_if.candidate_bits;
              seen_nxt      = in_if.seen_bits;
              vis_nxt       = in_if.seen_bits;
              np_nxt        = np_sat;
              off_nxt       = '0;
              state_nxt     = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        plane_nxt = '0;
        if (off_r[sfcb_pkg::OFF_W]) begin
          state_nxt = ST_DONE;
        end else if (!tested) begin
          off_nxt = off_r + 1'b1;
        end else if (np_r == '0) begin
          vis_nxt[bit_sel] = 1'b1;
          off_nxt          = off_r + 1'b1;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        mac_ctl.clear = 1'b1;
        k_nxt         = 2'd0;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        mac_ctl.mul = 1'b1;
        mac_ctl.acc = (k_r != 2'd0);
        k_nxt       = k_r + 1'b1;
        if (k_r == 2'd3) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        mac_ctl.acc = 1'b1;
        state_nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        if (not_pos) begin
          off_nxt   = off_r + 1'b1;
          state_nxt = ST_SCAN;
        end else if (plane_r + 1'b1 == np_r) begin
          vis_nxt[bit_sel] = 1'b1;
          off_nxt          = off_r + 1'b1;
          state_nxt        = ST_SCAN;
        end else begin
          plane_nxt = plane_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bits_nxt  = vis_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      plane_count_r <= '0;
      draw_en_r     <= 1'b1;
      k_r           <= 2'd0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      plane_count_r <= plane_count_nxt;
      draw_en_r     <= draw_en_nxt;
      k_r           <= k_nxt;
    end
    out_bits_r <= out_bits_nxt;
    np_r       <= np_nxt;
    plane_r    <= plane_nxt;
    idx_r      <= idx_nxt;
    cand_r     <= cand_nxt;
    seen_r     <= seen_nxt;
    vis_r      <= vis_nxt;
    off_r      <= off_nxt;
  end

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.op != sfcb_pkg::OP_CULL) |=> (out_if.valid && out_if.visible_bits == '0))
    else $error("load transfer did not produce a zero result");

  a_seen_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> ((vis_r & seen_r) == seen_r))
    else $error("prior visibility flag was lost during a cull");

  a_vis_from_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> ((vis_r & ~(seen_r | cand_r)) == '0))
    else $error("visibility set for an entity outside the candidate mask");

  a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (plane_r < np_r))
    else $error("plane counter ran past the plane count");

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_if.valid && state_r == ST_IDLE))
    else $error("cull result not handed to the output register");

endmodule
